// File: design/scti_pkg.sv
// Shared constants for the sine/cosine table interpolator: widths, phase offsets, quarter-wave table.
package scti_pkg;

    localparam int ANGLE_W   = 16;
    localparam int PHASE_W   = 15;
    localparam int FRAC_W    = 8;
    localparam int SEG_W     = 5;
    localparam int TAB_IDX_W = SEG_W + 1;
    localparam int MAG_W     = 15;
    localparam int VALUE_W   = 16;
    localparam int TAB_DEPTH = (1 << SEG_W) + 1;

    // cosine phase offset, one step short of three quarters of a turn
    localparam int COS_OFFSET = 24575;
    localparam logic [PHASE_W-1:0] COS_STEP = PHASE_W'((1 << PHASE_W) - COS_OFFSET);

    localparam logic MODE_SIN = 1'b0;
    localparam logic MODE_COS = 1'b1;

    localparam logic [MAG_W-1:0] QUARTER_WAVE [TAB_DEPTH] = '{
        15'h0000, 15'h0647, 15'h0c8b, 15'h12c7, 15'h18f8, 15'h1f19, 15'h2527, 15'h2b1e,
        15'h30fb, 15'h36b9, 15'h3c56, 15'h41cd, 15'h471c, 15'h4c3f, 15'h5133, 15'h55f4,
        15'h5a81, 15'h5ed6, 15'h62f1, 15'h66ce, 15'h6a6c, 15'h6dc9, 15'h70e1, 15'h73b5,
        15'h7640, 15'h7883, 15'h7a7c, 15'h7c29, 15'h7d89, 15'h7e9c, 15'h7f61, 15'h7fd7,
        15'h7fff
    };

endpackage

// File: design/scti_eval.sv
// Combinational phase fold, table lookup, linear interpolation and sign for one word.
module scti_eval
(
    input  logic                                mode,
    input  logic signed [scti_pkg::ANGLE_W-1:0] angle,
    output logic signed [scti_pkg::VALUE_W-1:0] value
);

    logic [scti_pkg::PHASE_W-1:0]         phase;
    logic [scti_pkg::SEG_W-1:0]           seg;
    logic [scti_pkg::FRAC_W-1:0]          frac;
    logic [scti_pkg::TAB_IDX_W-1:0]       idx_lo;
    logic [scti_pkg::TAB_IDX_W-1:0]       idx_hi;
    logic [scti_pkg::MAG_W-1:0]           lo;
    logic [scti_pkg::MAG_W-1:0]           hi;
    logic [scti_pkg::MAG_W-1:0]           diff;
    logic [scti_pkg::MAG_W+scti_pkg::FRAC_W-1:0] prod;
    logic [scti_pkg::MAG_W-1:0]           mag;

    always_comb
    begin
        phase = angle[scti_pkg::PHASE_W-1:0];
        if (mode == scti_pkg::MODE_COS)
        begin
            phase = phase + scti_pkg::COS_STEP;
        end

        seg  = phase[scti_pkg::FRAC_W +: scti_pkg::SEG_W];
        frac = phase[scti_pkg::FRAC_W-1:0];
        // mirrored quarter: walk the table backwards
        if (phase[scti_pkg::PHASE_W-2])
        begin
            seg  = ~seg;
            frac = ~frac;
        end

        idx_lo = {1'b0, seg};
        idx_hi = idx_lo + scti_pkg::TAB_IDX_W'(1);
        lo     = scti_pkg::QUARTER_WAVE[idx_lo];
        hi     = scti_pkg::QUARTER_WAVE[idx_hi];
        diff   = hi - lo;  // table is monotonic, never negative
        prod   = diff * frac;
        mag    = lo + prod[scti_pkg::FRAC_W +: scti_pkg::MAG_W];

        if (phase[scti_pkg::PHASE_W-1])
        begin
            value = -$signed({1'b0, mag});
        end
        else
        begin
            value = $signed({1'b0, mag});
        end
    end

endmodule

// File: design/sine_cosine_table_interpolator.sv
// Top level: Q15 sine/cosine by quarter-wave table interpolation, two-register pipeline.
//
//  channel | signals                       | direction | word
//  --------+-------------------------------+-----------+-----------------------------
//  in      | in_valid, in_stall, mode,     | in        | mode (0 sine, 1 cosine),
//          | angle                         |           | angle (low 15 bits = 1 turn)
//  out     | out_valid, out_stall, value   | out       | value, Q15 in -32767..32767
//
//  The accepted word lands in the input register at the accepting edge, and its
//  result enters the result register once adv lets that register load.
//  One word is taken every cycle while out is not stalled; the lookup, multiply
//  and add form the single pass between the two registers.
//  Reset clears both valid bits; data registers are not reset.
//  A stall on out holds the result register, and in_stall rises only when the
//  input register is also full, so both registers fill before input backs up.
module sine_cosine_table_interpolator
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                mode,
    input  logic signed [scti_pkg::ANGLE_W-1:0] angle,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [scti_pkg::VALUE_W-1:0] value
);

    // input register
    logic                                s1_valid_reg;
    logic                                s1_mode_reg;
    logic signed [scti_pkg::ANGLE_W-1:0] s1_angle_reg;

    // result register
    logic                                out_valid_reg;
    logic signed [scti_pkg::VALUE_W-1:0] value_reg;

    logic                                adv;      // result register may load
    logic                                s1_load;  // input register may load
    logic signed [scti_pkg::VALUE_W-1:0] value_next;

    assign adv      = !out_valid_reg || !out_stall;
    assign s1_load  = !s1_valid_reg || adv;
    assign in_stall = !s1_load;

    scti_eval u_eval
    (
        .mode  (s1_mode_reg),
        .angle (s1_angle_reg),
        .value (value_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= in_valid;
            end
            if (adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
        begin
            s1_mode_reg  <= mode;
            s1_angle_reg <= angle;
        end
        if (adv && s1_valid_reg)
        begin
            value_reg <= value_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;

`ifndef NO_ASSERTIONS
    // input backs up only when both registers hold a word
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("in_stall raised with a free register");

    // an accepted word always occupies the input register next cycle
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_valid_reg)
        else $error("accepted word lost");

    // a word in the input register reaches the output when it may advance
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && adv) |=> out_valid_reg)
        else $error("word dropped between stages");

    // magnitude never exceeds full scale, so -32768 never appears
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (value != 16'sh8000))
        else $error("value out of Q15 range");
`endif

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the Q15 sine/cosine table interpolator.
`timescale 1ns / 1ps

module testbench;

    // 32768 - 24575: cosine advance, one step past a true quarter turn
    localparam logic [14:0] COS_ADVANCE = 15'd8193;
    localparam int          RANDOM_WORDS = 1800;

    // quarter-wave magnitudes, 32 segments plus the closing point
    localparam logic [14:0] SINE_QUARTER [33] = '{
        15'h0000, 15'h0647, 15'h0c8b, 15'h12c7, 15'h18f8, 15'h1f19, 15'h2527, 15'h2b1e,
        15'h30fb, 15'h36b9, 15'h3c56, 15'h41cd, 15'h471c, 15'h4c3f, 15'h5133, 15'h55f4,
        15'h5a81, 15'h5ed6, 15'h62f1, 15'h66ce, 15'h6a6c, 15'h6dc9, 15'h70e1, 15'h73b5,
        15'h7640, 15'h7883, 15'h7a7c, 15'h7c29, 15'h7d89, 15'h7e9c, 15'h7f61, 15'h7fd7,
        15'h7fff
    };

    // one word expected on the out channel, with the input that caused it
    typedef struct {
        logic               m;
        logic signed [15:0] a;
        logic signed [15:0] v;
    } sample_t;

    // directed stimulus row; v is only used where known is set
    typedef struct {
        logic               m;
        logic signed [15:0] a;
        bit                 known;
        logic signed [15:0] v;
    } vec_t;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic               mode      = scti_pkg::MODE_SIN;
    logic signed [15:0] angle     = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] value;

    sample_t pending_samples [$];
    int      mismatches = 0;

    sine_cosine_table_interpolator DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .angle     (angle),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog. Slowest correct run is roughly 1825 words, slowed by sender gaps
    // and heavy receiver stalls; the timeout leaves ample margin above it.
    initial
    begin
        #2_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    // Expected output for one word. The low 15 bits of the angle are one turn;
    // cosine advances the phase, bit 13 mirrors the quarter, bit 14 negates.
    function automatic logic signed [15:0] sincos_q15(input logic m,
                                                      input logic [15:0] a);
        logic [14:0] ph;
        logic [4:0]  seg;
        logic [7:0]  frac;
        logic [14:0] lo;
        logic [14:0] hi;
        logic [22:0] prod;
        logic [14:0] mag;
        ph = a[14:0];
        if (m == scti_pkg::MODE_COS)
            ph = ph + COS_ADVANCE;
        seg  = ph[12:8];
        frac = ph[7:0];
        if (ph[13])
        begin
            seg  = 5'd31 - seg;
            frac = 8'd255 - frac;
        end
        lo   = SINE_QUARTER[seg];
        hi   = SINE_QUARTER[int'(seg) + 1];
        // table is monotonic, so the slope is never negative and the shift floors
        prod = (hi - lo) * frac;
        mag  = lo + prod[22:8];
        if (ph[14])
            return -$signed({1'b0, mag});
        return $signed({1'b0, mag});
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    // Present one word and hold it until taken. Called just after a rising
    // edge; returns just after the edge that accepted the word, so the next
    // call (or an idle) makes the only assignment to in_valid in that step.
    task automatic send_word(input logic m, input logic signed [15:0] a,
                             input bit known, input logic signed [15:0] v);
        sample_t s;
        mode     <= m;
        angle    <= a;
        in_valid <= 1'b1;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        s.m = m;
        s.a = a;
        s.v = known ? v : sincos_q15(m, a);
        pending_samples.push_back(s);
        @(posedge clk);
    endtask

    task automatic idle_cycles(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Random angle: mostly uniform, plus segment edges and quarter boundaries.
    function automatic logic signed [15:0] pick_angle();
        logic [15:0] a;
        a = 16'($urandom_range(0, 65535));
        case ($urandom_range(0, 3))
            2:
            begin
                case ($urandom_range(0, 3))
                    0: a[7:0] = 8'h00;
                    1: a[7:0] = 8'h01;
                    2: a[7:0] = 8'hfe;
                    default: a[7:0] = 8'hff;
                endcase
            end
            3: a = {a[15:13], 13'h0} + 16'($signed($urandom_range(0, 4)) - 2);
            default: ;
        endcase
        return $signed(a);
    endfunction

    // Receiver: out_stall follows a style that is redrawn at random intervals:
    // never stall, light, heavy, or alternating.
    int stall_style = 0;
    int style_left  = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            stall_style <= 0;
            style_left  <= 0;
        end
        else
        begin
            if (style_left == 0)
            begin
                stall_style <= $urandom_range(0, 3);
                style_left  <= $urandom_range(5, 60);
            end
            else
                style_left <= style_left - 1;
            case (stall_style)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 9) < 2);
                2: out_stall <= ($urandom_range(0, 9) < 7);
                default: out_stall <= ~out_stall;
            endcase
        end
    end

    // Out channel check. Sampled at the falling edge: valid and stall are
    // settled there and hold until the rising edge that takes the word.
    always @(negedge clk)
    begin
        sample_t s;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_samples.size() == 0)
                report_mismatch($sformatf("unexpected word, value %0d", value));
            else
            begin
                s = pending_samples.pop_front();
                if (value !== s.v)
                    report_mismatch($sformatf("mode %0d angle %0d: value %0d, want %0d",
                                              s.m, s.a, value, s.v));
            end
        end
    end

    // Directed rows: zero crossings, the first table step, negation of zero,
    // sign bit ignored, segment and quarter edges, the cosine offset.
    vec_t directed [22];

    initial
    begin
        int burst;
        int sent;
        directed = '{
            '{scti_pkg::MODE_SIN, 16'sh0000, 1'b1, 16'sd0},      // phase zero
            '{scti_pkg::MODE_SIN, 16'sh0100, 1'b1, 16'sd1607},   // first table step
            '{scti_pkg::MODE_SIN, 16'sh4000, 1'b1, 16'sd0},      // negated zero stays zero
            '{scti_pkg::MODE_SIN, 16'sh4100, 1'b1, -16'sd1607},  // negated first step
            '{scti_pkg::MODE_SIN, -16'sd32768, 1'b1, 16'sd0},    // sign bit is dropped
            '{scti_pkg::MODE_SIN, -16'sd32512, 1'b1, 16'sd1607}, // negative angle wraps
            '{scti_pkg::MODE_COS, 16'sd24575, 1'b1, 16'sd0},     // cosine offset gives zero
            '{scti_pkg::MODE_SIN, 16'sh00ff, 1'b0, 16'sd0},
            '{scti_pkg::MODE_SIN, 16'sh1fff, 1'b0, 16'sd0},      // top of first quarter
            '{scti_pkg::MODE_SIN, 16'sh2000, 1'b0, 16'sd0},      // mirrored quarter start
            '{scti_pkg::MODE_SIN, 16'sh3fff, 1'b0, 16'sd0},
            '{scti_pkg::MODE_SIN, 16'sh5fff, 1'b0, 16'sd0},
            '{scti_pkg::MODE_SIN, 16'sh6000, 1'b0, 16'sd0},
            '{scti_pkg::MODE_SIN, 16'sh7fff, 1'b0, 16'sd0},
            '{scti_pkg::MODE_SIN, -16'sd1,   1'b0, 16'sd0},
            '{scti_pkg::MODE_SIN, 16'sh2aaa, 1'b0, 16'sd0},
            '{scti_pkg::MODE_SIN, -16'sd21846, 1'b0, 16'sd0},
            '{scti_pkg::MODE_COS, 16'sd24576, 1'b0, 16'sd0},
            '{scti_pkg::MODE_COS, 16'sh0000, 1'b0, 16'sd0},
            '{scti_pkg::MODE_COS, 16'sd8191,  1'b0, 16'sd0},
            '{scti_pkg::MODE_COS, 16'sh7fff, 1'b0, 16'sd0},
            '{scti_pkg::MODE_COS, -16'sd32768, 1'b0, 16'sd0}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_word(directed[i].m, directed[i].a, directed[i].known, directed[i].v);

        // random bursts; twice along the way the sender drains the pipeline
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < RANDOM_WORDS; k++)
            begin
                send_word(logic'($urandom_range(0, 1)), pick_angle(), 1'b0, 16'sd0);
                sent++;
            end
            if ((sent >= 600 && sent - burst < 600) || (sent >= 1200 && sent - burst < 1200))
            begin
                in_valid <= 1'b0;
                while (pending_samples.size() != 0)
                    @(posedge clk);
            end
            else if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 8));
        end
        in_valid <= 1'b0;

        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
